// ===== rtl/core/pls_pkg.sv =====
// shared constants and types of the polyline length stack
`default_nettype none
package pls_pkg;

  localparam int unsigned MAX_POINTS_DEF = 10;
  localparam int unsigned COORD_BITS_DEF = 16;

  localparam int unsigned SEG_BITS       = 25;
  localparam int unsigned SUM_BITS       = 28;
  localparam int unsigned COUNT_OUT_BITS = 4;
  localparam int unsigned STATUS_BITS    = 2;

  localparam int unsigned RAD_BITS       = 50;
  localparam int unsigned ROOT_BITS      = 25;
  localparam int unsigned SAT_SHIFT      = 34;
  localparam int unsigned FRAC_SHIFT     = 16;

  localparam logic [SEG_BITS-1:0] SEG_MAX = {SEG_BITS{1'b1}};
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/pls_item_if.sv =====
// input word channel: opcode and point coordinates
`default_nettype none
interface pls_item_if #(
  parameter int unsigned COORD_BITS = pls_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;

  modport source (output valid, output opcode, output point_x, output point_y, input ready);
  modport sink (input valid, input opcode, input point_x, input point_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pls_result_if.sv =====
// result word channel: total length, point count and status
`default_nettype none
interface pls_result_if;
  logic                                valid;
  logic                                ready;
  logic [pls_pkg::SUM_BITS-1:0]        total_length;
  logic [pls_pkg::COUNT_OUT_BITS-1:0]  point_count;
  logic [pls_pkg::STATUS_BITS-1:0]     status;

  modport source (output valid, output total_length, output point_count, output status,
                  input ready);
  modport sink (input valid, input total_length, input point_count, input status,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pls_isqrt.sv =====
// iterative integer square root, two radicand bits per cycle
`default_nettype none
module pls_isqrt (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [pls_pkg::RAD_BITS-1:0]      radicand,
  output logic      [pls_pkg::ROOT_BITS-1:0]     root,
  output pls_pkg::sqrt_stat_t                    stat
);
  import pls_pkg::*;

  localparam logic [RAD_BITS-1:0] BIT_START = RAD_BITS'(1) << (RAD_BITS - 2);

  logic [RAD_BITS-1:0] rem;
  logic [RAD_BITS-1:0] res;
  logic [RAD_BITS-1:0] bitpos;
  logic                busy;
  logic                done;
  logic [RAD_BITS-1:0] trial;

  assign trial = res + bitpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitpos[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= radicand;
      res    <= '0;
      bitpos <= BIT_START;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitpos;
      end else begin
        res <= res >> 1;
      end
      bitpos <= bitpos >> 2;
    end
  end

  assign root      = res[ROOT_BITS-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("square root restarted while busy");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("square root done without a preceding run");
  a_root_fits: assert property (@(posedge clk) disable iff (rst)
    done |-> (res >> ROOT_BITS) == '0)
    else $error("square root result too wide");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/polyline_length_stack_core.sv =====
// polyline length stack: vertex store, sequencer and running length total
// Each input word adds a vertex or removes the last one and yields one result word with the
// total length (unsigned Q8), the point count and a status. A refused word and the first
// vertex go from acceptance straight to the result load, a removal through its update state
// first; an add after an existing vertex passes through the difference, two squarings on one
// shared multiplier, the sum, 25 iterations in the square root unit (two radicand bits a
// cycle) until it reports done, the update and the result load. A squared distance too large
// for the root skips it. The input is ready again the cycle after the result load, and the
// block waits in its last state while an earlier result is still held. One word is worked
// on at a time; the next one is taken while a finished result still waits.
// Vertex and segment stores are memories with a registered read and need no clearing.
`default_nettype none
module polyline_length_stack_core #(
  parameter int unsigned MAX_POINTS = pls_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = pls_pkg::COORD_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  pls_item_if.sink           item,
  pls_result_if.source       result
);
  import pls_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_POINTS);
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned SW  = PW + 1;
  localparam int unsigned SW1 = SUM_BITS + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_SQX  = 4'd2;
  localparam logic [3:0] S_SQY  = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_ROOT = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_REM  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]                   state;
  logic [CW-1:0]                count;
  logic [SUM_BITS-1:0]          length_sum;
  logic signed [COORD_BITS-1:0] x_reg;
  logic signed [COORD_BITS-1:0] y_reg;
  logic [STATUS_BITS-1:0]       status_reg;

  logic [2*COORD_BITS-1:0]      vtx_mem [MAX_POINTS];
  logic [SEG_BITS-1:0]          seg_mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0]      vtx_rd;
  logic [SEG_BITS-1:0]          seg_rd;

  logic [DW-1:0]                ax;
  logic [DW-1:0]                ay;
  logic [PW-1:0]                sq_x;
  logic [PW-1:0]                sq_y;
  logic                         sat;

  logic                         res_valid;
  logic [SUM_BITS-1:0]          res_total;
  logic [COUNT_OUT_BITS-1:0]    res_count;
  logic [STATUS_BITS-1:0]       res_status;

  logic                         accept;
  logic [CW-1:0]                count_m1;
  logic [IW-1:0]                rd_idx;
  logic [IW-1:0]                wr_idx;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic signed [DW-1:0]         dx;
  logic signed [DW-1:0]         dy;
  logic [DW-1:0]                mul_a;
  logic [PW-1:0]                product;
  logic [SW-1:0]                sq_sum;
  logic [RAD_BITS-1:0]          radicand;
  logic                         sqrt_start;
  logic [ROOT_BITS-1:0]         root;
  sqrt_stat_t                   sqrt_stat;
  logic [SEG_BITS-1:0]          seg_len;
  logic [SW1-1:0]               sum_add;
  logic                         load_res;

  assign accept   = item.valid && item.ready;
  assign count_m1 = count - CW'(1);
  assign rd_idx   = count_m1[IW-1:0];
  assign wr_idx   = count[IW-1:0];

  // vertex and segment stores
  always_ff @(posedge clk) begin
    if (accept && item.opcode == OP_ADD && count != CW'(MAX_POINTS)) begin
      vtx_mem[wr_idx] <= {item.point_x, item.point_y};
    end
    vtx_rd <= vtx_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_ACC) begin
      seg_mem[wr_idx] <= seg_len;
    end
    seg_rd <= seg_mem[rd_idx];
  end

  // shared datapath
  assign prev_x  = vtx_rd[2*COORD_BITS-1:COORD_BITS];
  assign prev_y  = vtx_rd[COORD_BITS-1:0];
  assign dx      = DW'(x_reg) - DW'(prev_x);
  assign dy      = DW'(y_reg) - DW'(prev_y);
  assign mul_a   = (state == S_SQX) ? ax : ay;
  assign product = PW'(mul_a) * PW'(mul_a);
  assign sq_sum  = SW'(sq_x) + SW'(sq_y);
  assign radicand = RAD_BITS'(sq_sum) << FRAC_SHIFT;
  assign sqrt_start = (state == S_SUM) && ((sq_sum >> SAT_SHIFT) == '0);
  assign seg_len = sat ? SEG_MAX : SEG_BITS'(root);
  assign sum_add = SW1'(length_sum) + SW1'(seg_len);
  assign load_res = (state == S_DONE) && (!res_valid || result.ready);

  pls_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .root     (root),
    .stat     (sqrt_stat)
  );

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          x_reg <= item.point_x;
          y_reg <= item.point_y;
        end
      end
      S_DIFF: begin
        ax <= dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay <= dy[DW-1] ? DW'(-dy) : DW'(dy);
      end
      S_SQX: sq_x <= product;
      S_SQY: sq_y <= product;
      S_SUM: sat <= (sq_sum >> SAT_SHIFT) != '0;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      length_sum <= '0;
      status_reg <= ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            status_reg <= ST_OK;
            if (item.opcode == OP_ADD) begin
              if (count == CW'(MAX_POINTS)) begin
                status_reg <= ST_FULL;
                state      <= S_DONE;
              end else if (count == '0) begin
                count <= count + CW'(1);
                state <= S_DONE;
              end else begin
                state <= S_DIFF;
              end
            end else begin
              if (count == '0) begin
                status_reg <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                state <= S_REM;
              end
            end
          end
        end
        S_DIFF: state <= S_SQX;
        S_SQX:  state <= S_SQY;
        S_SQY:  state <= S_SUM;
        S_SUM: begin
          state <= ((sq_sum >> SAT_SHIFT) != '0) ? S_ACC : S_ROOT;
        end
        S_ROOT: begin
          if (sqrt_stat.done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          length_sum <= sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
          count      <= count + CW'(1);
          state      <= S_DONE;
        end
        S_REM: begin
          if (count != CW'(1)) begin
            length_sum <= (length_sum > SUM_BITS'(seg_rd)) ?
                          length_sum - SUM_BITS'(seg_rd) : '0;
          end
          count <= count_m1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (load_res) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_total  <= length_sum;
      res_count  <= COUNT_OUT_BITS'(count);
      res_status <= status_reg;
    end
  end

  assign item.ready          = (state == S_IDLE);
  assign result.valid        = res_valid;
  assign result.total_length = res_total;
  assign result.point_count  = res_count;
  assign result.status       = res_status;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");
  a_sum_zero_short: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(1) |-> length_sum == '0)
    else $error("nonzero total with fewer than two points");
  a_root_in_state: assert property (@(posedge clk) disable iff (rst)
    sqrt_stat.done || sqrt_stat.busy |-> state == S_ROOT)
    else $error("square root running outside its state");
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && status_reg == ST_FULL |-> count == CW'(MAX_POINTS))
    else $error("full reported below capacity");
`endif

endmodule
`default_nettype wire

// ===== tb/polyline_length_stack_checker.sv =====
// checker for the polyline length stack: watches both channels, predicts and compares
module polyline_length_stack_checker #(
  parameter int unsigned MAX_POINTS = pls_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = pls_pkg::COORD_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  pls_item_if   item_mon,
  pls_result_if result_mon,
  output int    error_count,
  output int    outstanding,
  output int    report_count,
  output int    full_count,
  output int    empty_count
);
  import pls_pkg::*;

  typedef struct packed {
    logic [SUM_BITS-1:0]       total;
    logic [COUNT_OUT_BITS-1:0] count;
    logic [STATUS_BITS-1:0]    status;
  } length_report_t;

  logic signed [COORD_BITS-1:0] vert_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] vert_y [MAX_POINTS];
  logic [SEG_BITS-1:0]          seg_store [MAX_POINTS];
  int unsigned                  depth = 0;
  logic [SUM_BITS-1:0]          path_total = '0;
  length_report_t               report_q [$];
  int errs = 0;
  int reports = 0;
  int fulls = 0;
  int empties = 0;

  function automatic logic [ROOT_BITS-1:0] floor_root(input logic [RAD_BITS-1:0] rad);
    logic [ROOT_BITS-1:0] root;
    logic [ROOT_BITS-1:0] cand;
    root = '0;
    for (int i = ROOT_BITS - 1; i >= 0; i--) begin
      cand = root;
      cand[i] = 1'b1;
      if (64'(cand) * 64'(cand) <= 64'(rad)) root = cand;
    end
    return root;
  endfunction

  function automatic logic [SEG_BITS-1:0] segment_q8(
    input logic signed [COORD_BITS-1:0] x0, input logic signed [COORD_BITS-1:0] y0,
    input logic signed [COORD_BITS-1:0] x1, input logic signed [COORD_BITS-1:0] y1
  );
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [63:0]                ax;
    logic [63:0]                ay;
    logic [63:0]                sq;
    dx = $signed({x1[COORD_BITS-1], x1}) - $signed({x0[COORD_BITS-1], x0});
    dy = $signed({y1[COORD_BITS-1], y1}) - $signed({y0[COORD_BITS-1], y0});
    ax = 64'(dx < 0 ? -dx : dx);
    ay = 64'(dy < 0 ? -dy : dy);
    sq = ax * ax + ay * ay;
    if (sq >= (64'd1 << SAT_SHIFT)) return SEG_MAX;
    return SEG_BITS'(floor_root(RAD_BITS'(sq << FRAC_SHIFT)));
  endfunction

  function automatic length_report_t apply_word(
    input logic op, input logic signed [COORD_BITS-1:0] px,
    input logic signed [COORD_BITS-1:0] py
  );
    length_report_t      rep;
    logic [SEG_BITS-1:0] len;
    logic [SUM_BITS:0]   wide;
    rep.status = ST_OK;
    if (op == OP_ADD) begin
      if (depth >= MAX_POINTS) begin
        rep.status = ST_FULL;
      end else begin
        len = '0;
        if (depth > 0) len = segment_q8(vert_x[depth-1], vert_y[depth-1], px, py);
        vert_x[depth] = px;
        vert_y[depth] = py;
        seg_store[depth] = len;
        wide = path_total + len;
        path_total = (wide > SUM_MAX) ? SUM_MAX : wide[SUM_BITS-1:0];
        depth++;
      end
    end else begin
      if (depth == 0) begin
        rep.status = ST_EMPTY;
      end else begin
        // the first vertex carries no segment
        if (depth > 1) begin
          path_total = (path_total > seg_store[depth-1]) ? path_total - seg_store[depth-1] : '0;
        end
        depth--;
      end
    end
    rep.total = path_total;
    rep.count = COUNT_OUT_BITS'(depth);
    return rep;
  endfunction

  always @(posedge clk) begin : watch
    length_report_t want;
    if (rst) begin
      report_q.delete();
      depth = 0;
      path_total = '0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        reports++;
        if (report_q.size() == 0) begin
          $display("%0t: result word with nothing expected: total_length %0d point_count %0d status %0d",
                   $time, result_mon.total_length, result_mon.point_count, result_mon.status);
          errs++;
        end else begin
          want = report_q.pop_front();
          if (result_mon.total_length !== want.total) begin
            $display("%0t: total_length expected %0d, got %0d",
                     $time, want.total, result_mon.total_length);
            errs++;
          end
          if (result_mon.point_count !== want.count) begin
            $display("%0t: point_count expected %0d, got %0d",
                     $time, want.count, result_mon.point_count);
            errs++;
          end
          if (result_mon.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, result_mon.status);
            errs++;
          end
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        want = apply_word(item_mon.opcode, item_mon.point_x, item_mon.point_y);
        if (want.status == ST_FULL) fulls++;
        if (want.status == ST_EMPTY) empties++;
        report_q.push_back(want);
      end
    end
    outstanding  <= report_q.size();
    error_count  <= errs;
    report_count <= reports;
    full_count   <= fulls;
    empty_count  <= empties;
  end

endmodule

// ===== tb/polyline_length_stack_core_test.sv =====
// testbench top for the polyline length stack: clock, reset, stimulus and verdict
module polyline_length_stack_core_test;
  import pls_pkg::*;

  localparam int unsigned CB           = COORD_BITS_DEF;
  localparam int          RANDOM_WORDS = 500;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          LONG_HOLD    = 400;

  logic clk;
  logic rst;
  logic hold_request;
  logic steady_ready;
  int   adds_sent = 0;
  int   removes_sent = 0;
  int   cycle_count = 0;
  int   error_count;
  int   outstanding;
  int   report_count;
  int   full_count;
  int   empty_count;

  pls_item_if #(.COORD_BITS(CB)) item_ch ();
  pls_result_if                  result_ch ();

  polyline_length_stack_core #(
    .MAX_POINTS(MAX_POINTS_DEF),
    .COORD_BITS(CB)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  polyline_length_stack_checker #(
    .MAX_POINTS(MAX_POINTS_DEF),
    .COORD_BITS(CB)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_mon     (item_ch),
    .result_mon   (result_ch),
    .error_count  (error_count),
    .outstanding  (outstanding),
    .report_count (report_count),
    .full_count   (full_count),
    .empty_count  (empty_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int burst_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int idle_gap(input bit quiet);
    if (quiet || $urandom_range(0, 99) < 60) return 0;
    return burst_len();
  endfunction

  function automatic int pick_coord(input int near);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return -32768;
          1:       return 32767;
          2:       return 0;
          default: return -1;
        endcase
      end
      1, 2, 3, 4: return int'($signed(CB'($urandom)));
      default:    return near + int'($urandom_range(0, 64)) - 32;
    endcase
  endfunction

  task automatic offer_word(input logic op, input int x, input int y, input int gap);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.opcode  <= op;
    item_ch.point_x <= CB'(x);
    item_ch.point_y <= CB'(y);
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (op == OP_ADD) adds_sent++;
    else removes_sent++;
  endtask

  // result side: short random stalls, one long hold-off on request
  initial begin : result_sink
    int stall_left;
    bit hold_started;
    stall_left = 0;
    hold_started = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_started) begin
        hold_started = 1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (steady_ready || $urandom_range(0, 99) < 80) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b0;
        stall_left = burst_len() - 1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int   sent;
    int   run_len;
    logic run_op;
    logic op;
    int   x;
    int   y;
    int   last_x;
    int   last_y;
    bit   quiet;
    sent = 0;
    last_x = 0;
    last_y = 0;
    rst             <= 1'b1;
    item_ch.valid   <= 1'b0;
    item_ch.opcode  <= OP_ADD;
    item_ch.point_x <= '0;
    item_ch.point_y <= '0;
    hold_request    <= 1'b0;
    steady_ready    <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty removal, corner points, zero segment, full, drain to empty
    offer_word(OP_REMOVE, 32767, -32768, idle_gap(0));
    offer_word(OP_ADD, -32768, -32768, idle_gap(0));
    offer_word(OP_ADD, 32767, 32767, idle_gap(0));
    offer_word(OP_ADD, -32768, 32767, idle_gap(0));
    offer_word(OP_ADD, 32767, -32768, idle_gap(0));
    offer_word(OP_ADD, 0, 0, idle_gap(0));
    offer_word(OP_ADD, 0, 0, idle_gap(0));
    offer_word(OP_REMOVE, -1, -1, idle_gap(0));
    for (int i = 1; i <= 5; i++) offer_word(OP_ADD, i * 3, -i * 4, idle_gap(0));
    offer_word(OP_ADD, -1, -1, idle_gap(0));
    offer_word(OP_ADD, 32767, 32767, idle_gap(0));
    for (int i = 0; i < 10; i++) offer_word(OP_REMOVE, i, -i, idle_gap(0));
    offer_word(OP_REMOVE, 0, 0, idle_gap(0));

    // random runs of adds or removes with some words flipped
    while (sent < RANDOM_WORDS) begin
      run_len = $urandom_range(1, 12);
      run_op = ($urandom_range(0, 99) < 58) ? OP_ADD : OP_REMOVE;
      for (int k = 0; k < run_len && sent < RANDOM_WORDS; k++) begin
        if (sent == 100) steady_ready <= 1'b1;
        if (sent == 160) hold_request <= 1'b1;
        if (sent == 220) begin
          steady_ready <= 1'b0;
          hold_request <= 1'b0;
        end
        quiet = (sent >= 100 && sent < 220);
        op = ($urandom_range(0, 9) == 0) ? ~run_op : run_op;
        x = pick_coord(last_x);
        y = pick_coord(last_y);
        offer_word(op, x, y, idle_gap(quiet));
        if (op == OP_ADD) begin
          last_x = x;
          last_y = y;
        end
        sent++;
      end
    end
    item_ch.valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d adds, %0d removes, corner points and a %0d-cycle result hold",
             adds_sent + removes_sent, adds_sent, removes_sent, LONG_HOLD);
    $display("checked %0d results, %0d refused as full, %0d refused as empty",
             report_count, full_count, empty_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
